// ===== rtl/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

   // Component and result widths
   localparam int unsigned COMP_W = 8;
   localparam int unsigned QUO_W  = 8;

   // Hue angle numerator m in [0, 6*d), hue = floor(85*m / (2*d))
   localparam int unsigned M_W        = 11;
   localparam int unsigned HUE_REM_W  = 17;
   localparam int unsigned HUE_DIV_W  = COMP_W + 1;
   localparam int unsigned SAT_REM_W  = 16;
   localparam int unsigned SAT_DIV_W  = COMP_W;
   localparam int unsigned HUE_MUL    = 85;

   // Divider layout: quotient bits resolved per stage and number of stages
   localparam int unsigned BITS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

   // Total latency from accepted beat to result strobe
   localparam int unsigned PREP_STAGES = 3;
   localparam int unsigned LATENCY     = PREP_STAGES + DIV_STAGES;

   // Which component holds the maximum (red tested first, then green)
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } hue_sector_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [COMP_W-1:0] hue;
      logic [COMP_W-1:0] saturation;
      logic [COMP_W-1:0] brightness;
   } rsp_type;

   // Payload carried down the divider pipeline (both divisions side by side)
   typedef struct packed {
      logic [COMP_W-1:0]    brightness;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_DIV_W-1:0] sat_div;
      logic [QUO_W-1:0]     sat_quo;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_DIV_W-1:0] hue_div;
      logic [QUO_W-1:0]     hue_quo;
   } div_beat_type;

endpackage

// ===== rtl/rgbhsv_prep.sv =====
`timescale 1ns / 1ps

module rgbhsv_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rgbhsv_pkg::req_type        in_pixel,
   output logic                       out_valid,
   output rgbhsv_pkg::div_beat_type   out_beat
);

   localparam int unsigned CW = rgbhsv_pkg::COMP_W;
   localparam int unsigned MW = rgbhsv_pkg::M_W;
   localparam int unsigned SRW = rgbhsv_pkg::SAT_REM_W;
   localparam int unsigned HRW = rgbhsv_pkg::HUE_REM_W;
   localparam int unsigned HDW = rgbhsv_pkg::HUE_DIV_W;

   // Stage 1: max, min, difference and sector
   logic                        s1_valid_ff, s1_valid_in;
   logic [CW-1:0]               s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [CW-1:0]               s1_max_ff, s1_max_in;
   logic [CW-1:0]               s1_diff_ff, s1_diff_in;
   rgbhsv_pkg::hue_sector_type  s1_sector_ff, s1_sector_in;
   logic [CW-1:0]               min_val;

   // Stage 2: hue numerator m
   logic                        s2_valid_ff;
   logic [CW-1:0]               s2_max_ff;
   logic [CW-1:0]               s2_diff_ff;
   logic [MW-1:0]               s2_m_ff, s2_m_in;
   logic [MW-1:0]               m_base;
   logic [MW-1:0]               m_sub;

   // Stage 3: numerators and divisors
   logic                        s3_valid_ff;
   rgbhsv_pkg::div_beat_type    s3_beat_ff, s3_beat_in;

   assign s1_valid_in = in_valid;

   // Max with red-first tie break, min, difference
   always_comb begin
      if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
         s1_sector_in = rgbhsv_pkg::SECT_RED;
         s1_max_in    = in_pixel.red;
      end else if (in_pixel.green >= in_pixel.blue) begin
         s1_sector_in = rgbhsv_pkg::SECT_GREEN;
         s1_max_in    = in_pixel.green;
      end else begin
         s1_sector_in = rgbhsv_pkg::SECT_BLUE;
         s1_max_in    = in_pixel.blue;
      end
      min_val = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
      if (in_pixel.blue < min_val) begin
         min_val = in_pixel.blue;
      end
      s1_diff_in = s1_max_in - min_val;
   end

   // m = k*d + p - q, never negative for the chosen sector
   always_comb begin
      case (s1_sector_ff)
         rgbhsv_pkg::SECT_RED: begin
            if (s1_green_ff >= s1_blue_ff) begin
               m_base = MW'(s1_green_ff);
            end else begin
               m_base = (MW'(s1_diff_ff) << 2) + (MW'(s1_diff_ff) << 1)
                        + MW'(s1_green_ff);
            end
            m_sub = MW'(s1_blue_ff);
         end
         rgbhsv_pkg::SECT_GREEN: begin
            m_base = (MW'(s1_diff_ff) << 1) + MW'(s1_blue_ff);
            m_sub  = MW'(s1_red_ff);
         end
         default: begin
            m_base = (MW'(s1_diff_ff) << 2) + MW'(s1_red_ff);
            m_sub  = MW'(s1_green_ff);
         end
      endcase
      s2_m_in = m_base - m_sub;
   end

   // Constant multiplies; zero divisors become harmless since numerators are zero then
   always_comb begin
      s3_beat_in            = '0;
      s3_beat_in.brightness = s2_max_ff;
      s3_beat_in.sat_rem    = (SRW'(s2_diff_ff) << CW) - SRW'(s2_diff_ff);
      s3_beat_in.sat_div    = (s2_max_ff == '0) ? CW'(1) : s2_max_ff;
      s3_beat_in.hue_rem    = (HRW'(s2_m_ff) << 6) + (HRW'(s2_m_ff) << 4)
                              + (HRW'(s2_m_ff) << 2) + HRW'(s2_m_ff);
      s3_beat_in.hue_div    = (s2_diff_ff == '0) ? HDW'(2) : {s2_diff_ff, 1'b0};
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_red_ff    <= in_pixel.red;
      s1_green_ff  <= in_pixel.green;
      s1_blue_ff   <= in_pixel.blue;
      s1_max_ff    <= s1_max_in;
      s1_diff_ff   <= s1_diff_in;
      s1_sector_ff <= s1_sector_in;
      s2_max_ff    <= s1_max_ff;
      s2_diff_ff   <= s1_diff_ff;
      s2_m_ff      <= s2_m_in;
      s3_beat_ff   <= s3_beat_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_beat  = s3_beat_ff;

endmodule

// ===== rtl/rgbhsv_div_stage.sv =====
`timescale 1ns / 1ps

module rgbhsv_div_stage #(
   parameter int unsigned STAGE_IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rgbhsv_pkg::div_beat_type   in_beat,
   output logic                       out_valid,
   output rgbhsv_pkg::div_beat_type   out_beat
);

   localparam int unsigned BPS    = rgbhsv_pkg::BITS_PER_STAGE;
   localparam int unsigned QW     = rgbhsv_pkg::QUO_W;
   localparam int unsigned QIDX_W = $clog2(QW);
   localparam int unsigned SRW    = rgbhsv_pkg::SAT_REM_W;
   localparam int unsigned HRW    = rgbhsv_pkg::HUE_REM_W;
   localparam int unsigned HI_BIT = QW - 1 - BPS * STAGE_IDX;

   logic                      valid_ff;
   rgbhsv_pkg::div_beat_type  beat_ff, beat_in;

   // Restoring division, BPS quotient bits for both lanes
   always_comb begin
      int             step;
      logic [SRW-1:0] sat_shift;
      logic [HRW-1:0] hue_shift;
      beat_in = in_beat;
      for (int k = 0; k < BPS; k++) begin
         step      = HI_BIT - k;
         sat_shift = SRW'(beat_in.sat_div) << step;
         hue_shift = HRW'(beat_in.hue_div) << step;
         if (beat_in.sat_rem >= sat_shift) begin
            beat_in.sat_rem                     = beat_in.sat_rem - sat_shift;
            beat_in.sat_quo[step[QIDX_W-1:0]]   = 1'b1;
         end
         if (beat_in.hue_rem >= hue_shift) begin
            beat_in.hue_rem                     = beat_in.hue_rem - hue_shift;
            beat_in.hue_quo[step[QIDX_W-1:0]]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ===== rtl/rgb_to_hsv_pixel_core.sv =====
`timescale 1ns / 1ps

// RGB to HSV pixel converter. One pixel beat is taken on every clock that
// start is high; busy never rises, so there is no input backpressure. Each
// result appears on rsp_pixel with rsp_valid high for one cycle, once its
// beat has passed 3 preparation stages for max/min, the hue numerator and
// the constant multiplies, then 4 divider stages that each resolve two
// quotient bits of both divisions. Results come in input order and the
// receiver cannot stall them. Hue maps 360 degrees to 255 (0..254),
// saturation is floor(255*(max-min)/max), brightness is max;
// gray and black pixels give hue and saturation of zero.
module rgb_to_hsv_pixel_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rgbhsv_pkg::req_type  req_pixel,
   output logic                 rsp_valid,
   output rgbhsv_pkg::rsp_type  rsp_pixel
);

   localparam int unsigned NST = rgbhsv_pkg::DIV_STAGES;

   logic                      stage_valid [NST+1];
   rgbhsv_pkg::div_beat_type  stage_beat  [NST+1];

   // Pipeline never stalls
   assign busy = 1'b0;

   rgbhsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_pixel  (req_pixel),
      .out_valid (stage_valid[0]),
      .out_beat  (stage_beat[0])
   );

   // Divider chain
   for (genvar i = 0; i < NST; i++) begin : g_div
      rgbhsv_div_stage #(
         .STAGE_IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_beat   (stage_beat[i]),
         .out_valid (stage_valid[i+1]),
         .out_beat  (stage_beat[i+1])
      );
   end

   assign rsp_valid            = stage_valid[NST];
   assign rsp_pixel.hue        = stage_beat[NST].hue_quo;
   assign rsp_pixel.saturation = stage_beat[NST].sat_quo;
   assign rsp_pixel.brightness = stage_beat[NST].brightness;

   // Divider finished: remainders below their divisors
   a_rem_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (stage_beat[NST].sat_rem < 16'(stage_beat[NST].sat_div)) &&
                    (stage_beat[NST].hue_rem < 17'(stage_beat[NST].hue_div)))
      else $error("divider remainder not reduced");

   // Hue wraps below a full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel.hue != 8'hFF)
      else $error("hue out of range");

   // Zero saturation means a gray pixel, whose hue is zero
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel.saturation == 8'd0 |-> rsp_pixel.hue == 8'd0)
      else $error("gray pixel with nonzero hue");

endmodule
